@@ rtl/websocket_frame_builder_assert.svh @@
// assertion macros for the websocket frame builder
`ifndef WEBSOCKET_FRAME_BUILDER_ASSERT_SVH
`define WEBSOCKET_FRAME_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, masked while reset is active
`define WSFB_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("wsfb check failed");

// clocked check that also holds during reset
`define WSFB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("wsfb check failed");

`else

`define WSFB_ASSERT(label, clk, rstn, prop)
`define WSFB_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ rtl/wsfb_pkg.sv @@
`default_nettype none

package wsfb_pkg;

    // item kinds on s_tuser
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // register byte-address word index
    localparam logic REG_MASK_KEY = 1'b0;

    localparam logic [31:0] MASK_KEY_RESET = 32'h1234_5678;
    localparam logic [7:0]  TYPE_TEXT      = 8'd129;
    localparam logic [7:0]  MASK_BIT       = 8'h80;
    localparam logic [62:0] LEN_SHORT_MAX  = 63'd125;
    localparam logic [62:0] LEN_EXT16_MAX  = 63'd65535;
    localparam logic [6:0]  LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0]  LEN_CODE_EXT64 = 7'd127;

    // header step where the mask key begins, per length format
    localparam logic [3:0]  KEY_BASE_SHORT = 4'd2;
    localparam logic [3:0]  KEY_BASE_EXT16 = 4'd4;
    localparam logic [3:0]  KEY_BASE_EXT64 = 4'd10;

    typedef enum logic [1:0] {
        FMT_SHORT,
        FMT_EXT16,
        FMT_EXT64
    } len_fmt_t;

    // header serializer control
    typedef struct packed {
        len_fmt_t   fmt;
        logic [3:0] step;
    } hdr_ctl_t;

    // header serializer result
    typedef struct packed {
        logic [7:0] data;
        logic       last_step;
        logic       last_byte;
    } hdr_out_t;

endpackage

`default_nettype wire

@@ rtl/websocket_frame_builder.sv @@
// channel  | dir | tdata (low bit up)                                  | tuser | tlast
// s_       | in  | frame_type[7:0], payload_length[70:8], byte[78:71]  | kind  | -
// m_       | out | frame_byte[7:0]                                     | -     | last_byte
// apb      | in  | mask_key at byte address 0                          | -     | -
//
// a start item yields 6, 8 or 14 header bytes, one per cycle while the output drains,
// from the header serializer feeding the output byte register.
// frame state updates at input transfer, so a payload byte can be taken every cycle
// while m_tready allows. m_tready low holds the output register; s_tready drops
// while a header is pending. reset is synchronous; all control state clears, no sweep.
`default_nettype none

`include "websocket_frame_builder_assert.svh"

module websocket_frame_builder
    import wsfb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // frame_type, payload_length, payload_byte, pad
    input  wire logic        s_tuser,   // kind
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // frame_byte
    output logic             m_tlast,   // last_byte
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]  in_type;
    logic [62:0] in_len;
    logic [7:0]  in_byte;
    logic        in_kind;
    logic        s_xfer;
    logic        out_load;
    logic        hold_final;
    logic [7:0]  hold_data;
    logic        hold_last;

    logic [31:0] mask_key_reg;
    logic [62:0] bytes_left_reg, bytes_left_next;
    logic [1:0]  key_pos_reg, key_pos_next;
    logic        frame_open_reg, frame_open_next;

    logic        hold_valid_reg, hold_valid_next;
    logic        hold_kind_reg, hold_kind_next;
    logic [7:0]  hold_byte_reg, hold_byte_next;
    logic        hold_plast_reg, hold_plast_next;
    logic [62:0] hold_len_reg, hold_len_next;
    len_fmt_t    hold_fmt_reg, hold_fmt_next;
    logic [3:0]  hold_step_reg, hold_step_next;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    logic [31:0] key_rot;
    logic [7:0]  masked_byte;
    hdr_ctl_t    hdr_ctl;
    hdr_out_t    hdr;

    assign in_type = s_tdata[7:0];
    assign in_len  = s_tdata[70:8];
    assign in_byte = s_tdata[78:71];
    assign in_kind = s_tuser;

    // apb register port
    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_MASK_KEY: prdata = mask_key_reg;
            default:      prdata = 32'h0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_key_reg <= MASK_KEY_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MASK_KEY) begin
            mask_key_reg <= pwdata;
        end
    end

    // header serializer
    assign hdr_ctl = {hold_fmt_reg, hold_step_reg};

    wsfb_header_gen u_hdr (
        .ctl       (hdr_ctl),
        .type_byte (hold_byte_reg),
        .len       (hold_len_reg),
        .mask_key  (mask_key_reg),
        .hdr       (hdr)
    );

    // pending byte from the hold stage
    always_comb begin
        if (hold_kind_reg == KIND_PAYLOAD) begin
            hold_data  = hold_byte_reg;
            hold_last  = hold_plast_reg;
            hold_final = 1'b1;
        end else begin
            hold_data  = hdr.data;
            hold_last  = hdr.last_byte;
            hold_final = hdr.last_step;
        end
    end

    assign out_load = hold_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !hold_valid_reg || (out_load && hold_final);
    assign s_xfer   = s_tvalid && s_tready;

    // payload masking with the current key byte
    assign key_rot     = mask_key_reg << {key_pos_reg, 3'b000};
    assign masked_byte = in_byte ^ key_rot[31:24];

    // frame state and hold stage
    always_comb begin
        bytes_left_next = bytes_left_reg;
        key_pos_next    = key_pos_reg;
        frame_open_next = frame_open_reg;
        hold_valid_next = hold_valid_reg;
        hold_kind_next  = hold_kind_reg;
        hold_byte_next  = hold_byte_reg;
        hold_plast_next = hold_plast_reg;
        hold_len_next   = hold_len_reg;
        hold_fmt_next   = hold_fmt_reg;
        hold_step_next  = hold_step_reg;

        if (out_load) begin
            if (hold_final) begin
                hold_valid_next = 1'b0;
            end else begin
                hold_step_next = hold_step_reg + 4'd1;
            end
        end

        if (s_xfer) begin
            if (in_kind == KIND_START) begin
                bytes_left_next = in_len;
                key_pos_next    = 2'd0;
                frame_open_next = (in_len != 63'd0);
                hold_valid_next = 1'b1;
                hold_kind_next  = KIND_START;
                hold_byte_next  = (in_type == 8'd0) ? TYPE_TEXT : in_type;
                hold_plast_next = 1'b0;
                hold_len_next   = in_len;
                hold_step_next  = 4'd0;
                if (in_len <= LEN_SHORT_MAX) begin
                    hold_fmt_next = FMT_SHORT;
                end else if (in_len <= LEN_EXT16_MAX) begin
                    hold_fmt_next = FMT_EXT16;
                end else begin
                    hold_fmt_next = FMT_EXT64;
                end
            end else if (frame_open_reg) begin
                bytes_left_next = bytes_left_reg - 63'd1;
                key_pos_next    = key_pos_reg + 2'd1;
                frame_open_next = (bytes_left_reg != 63'd1);
                hold_valid_next = 1'b1;
                hold_kind_next  = KIND_PAYLOAD;
                hold_byte_next  = masked_byte;
                hold_plast_next = (bytes_left_reg == 63'd1);
                hold_step_next  = 4'd0;
            end
        end
    end

    // output byte register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = hold_data;
            m_last_next  = hold_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= 63'd0;
            key_pos_reg    <= 2'd0;
            frame_open_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_kind_reg  <= KIND_START;
            hold_fmt_reg   <= FMT_SHORT;
            hold_step_reg  <= 4'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            key_pos_reg    <= key_pos_next;
            frame_open_reg <= frame_open_next;
            hold_valid_reg <= hold_valid_next;
            hold_kind_reg  <= hold_kind_next;
            hold_fmt_reg   <= hold_fmt_next;
            hold_step_reg  <= hold_step_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_byte_reg  <= hold_byte_next;
        hold_plast_reg <= hold_plast_next;
        hold_len_reg   <= hold_len_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // checks
    `WSFB_ASSERT(a_open_matches_count, aclk, aresetn, frame_open_reg == (bytes_left_reg != 63'd0))
    `WSFB_ASSERT(a_take_only_on_drain, aclk, aresetn,
        (s_xfer && hold_valid_reg) |-> (out_load && hold_final))
    `WSFB_ASSERT(a_start_resets_key, aclk, aresetn,
        (s_xfer && in_kind == KIND_START) |=> (key_pos_reg == 2'd0 && hold_step_reg == 4'd0))
    `WSFB_ASSERT(a_step_in_range, aclk, aresetn, hold_valid_reg |-> hold_step_reg <= 4'd13)

endmodule

`default_nettype wire

@@ rtl/wsfb_header_gen.sv @@
`default_nettype none

module wsfb_header_gen
    import wsfb_pkg::*;
(
    input  wire hdr_ctl_t    ctl,
    input  wire logic [7:0]  type_byte,
    input  wire logic [62:0] len,
    input  wire logic [31:0] mask_key,
    output hdr_out_t         hdr
);

    logic [3:0]  key_base;
    logic [3:0]  key_off;
    logic [1:0]  key_idx;
    logic [2:0]  ext_idx;
    logic [2:0]  byte_sel;
    logic [2:0]  shift_sel;
    logic [63:0] len_ext;
    logic [63:0] len_shifted;
    logic [31:0] key_shifted;

    // key position within the header for this format
    always_comb begin
        case (ctl.fmt)
            FMT_SHORT: key_base = KEY_BASE_SHORT;
            FMT_EXT16: key_base = KEY_BASE_EXT16;
            FMT_EXT64: key_base = KEY_BASE_EXT64;
            default:   key_base = KEY_BASE_SHORT;
        endcase
    end

    assign key_off     = ctl.step - key_base;
    assign key_idx     = key_off[1:0];
    assign key_shifted = mask_key << {key_idx, 3'b000};

    // big-endian extended length byte, 16-bit form uses the two low bytes
    assign ext_idx     = 3'(ctl.step - 4'd2);
    assign byte_sel    = (ctl.fmt == FMT_EXT16) ? (ext_idx + 3'd6) : ext_idx;
    assign shift_sel   = ~byte_sel;
    assign len_ext     = {1'b0, len};
    assign len_shifted = len_ext >> {shift_sel, 3'b000};

    // byte mux over the header steps
    always_comb begin
        hdr.data      = 8'h00;
        hdr.last_step = 1'b0;
        hdr.last_byte = 1'b0;
        if (ctl.step >= key_base) begin
            hdr.data      = key_shifted[31:24];
            hdr.last_step = (key_idx == 2'd3);
            hdr.last_byte = (key_idx == 2'd3) && (len == 63'd0);
        end else if (ctl.step == 4'd0) begin
            hdr.data = type_byte;
        end else if (ctl.step == 4'd1) begin
            case (ctl.fmt)
                FMT_SHORT: hdr.data = MASK_BIT | {1'b0, len[6:0]};
                FMT_EXT16: hdr.data = MASK_BIT | {1'b0, LEN_CODE_EXT16};
                FMT_EXT64: hdr.data = MASK_BIT | {1'b0, LEN_CODE_EXT64};
                default:   hdr.data = MASK_BIT;
            endcase
        end else begin
            hdr.data = len_shifted[7:0];
        end
    end

endmodule

`default_nettype wire
